@@ rtl/fic_pkg.sv @@
// ----------------------------------------------------------------------------
// Firmware image checker package
// Types, codes and constants shared by the firmware image checker modules.
// ----------------------------------------------------------------------------
package fic_pkg;

   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned CSR_DATA_BITS  = 24;
   localparam int unsigned SIZE_BITS      = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SIZE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SIZE = 8'd1;

   localparam logic [SIZE_BITS-1:0] MIN_SIZE_RESET = 24'd1024;
   localparam logic [SIZE_BITS-1:0] MAX_SIZE_RESET = 24'hFF_FFFF;

   localparam logic [15:0] MOD_SUM = 16'hFFFF;

   localparam int unsigned PREFIX_LEN  = 8;
   localparam int unsigned OFF_VERSION = 'h0C;
   localparam int unsigned OFF_BUILD   = 'h10;
   localparam int unsigned OFF_REGIONS = 'h14;
   localparam int unsigned V3_MIN_LEN  = 'h18;
   localparam logic [31:0] MAX_REGIONS = 32'd64;

   localparam logic [7:0] MAGIC_V3 [PREFIX_LEN] = '{
      8'h5F, 8'h5F, 8'h4D, 8'h54, 8'h37, 8'h36, 8'h5F, 8'h5F
   };
   localparam logic [7:0] MAGIC_PATCH [PREFIX_LEN] = '{
      8'h4D, 8'h54, 8'h4B, 8'h5F, 8'h50, 8'h41, 8'h54, 8'h43
   };

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SIZE   = 2'd1,
      STATUS_REGION = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FLAVOUR_RAW   = 2'd0,
      FLAVOUR_V3    = 2'd1,
      FLAVOUR_PATCH = 2'd2
   } flavour_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type           status;
      flavour_type          flavour;
      logic [31:0]          image_version;
      logic [31:0]          build_stamp;
      logic [31:0]          num_regions;
      logic [31:0]          checksum;
      logic [SIZE_BITS-1:0] image_length;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] min_size;
      logic [SIZE_BITS-1:0] max_size;
   } cfg_type;

   // Add two 16-bit values modulo 0xFFFF; either input may itself be 0xFFFF.
   function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [15:0] r;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {MOD_SUM, 1'b0}) begin
         r = 16'd0;
      end else if (s >= {1'b0, MOD_SUM}) begin
         r = 16'(s - {1'b0, MOD_SUM});
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/firmware_image_checker_unit.sv @@
// ----------------------------------------------------------------------------
// Firmware image checker
// Streams a firmware image byte by byte, keeps a Fletcher-32 checksum,
// classifies the image by its magic prefix and checks size and region count.
//
//   Port group   Direction  Handshake          Transaction
//   req_*        in         req_valid/ready    one image byte and last flag
//   rsp_*        out        rsp_valid/ready    one result per image
//   csr_*        in         csr_we             write of a size limit
//
// Each byte is held in the input register and is then folded into the
// state, so a new byte is accepted every cycle unless the core stalls.
// The result is loaded into the output register as the core takes the final
// byte from the input register; the core stalls only on a final byte while
// an earlier result waits.
// Reset is synchronous; size limits return to defaults.
// ----------------------------------------------------------------------------
module firmware_image_checker_unit #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fic_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fic_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [fic_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fic_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import fic_pkg::*;

   cfg_type cfg;
   logic    item_valid;
   req_type item;
   logic    take;
   logic    out_free;
   logic    result_load;
   rsp_type result;

   fic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fic_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .take       (take)
   );

   fic_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .take        (take),
      .result_load (result_load),
      .result      (result)
   );

   fic_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_load),
      .data      (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/fic_csr.sv @@
// ----------------------------------------------------------------------------
// Firmware image checker configuration registers
// Holds the minimum and maximum image size limits written over the CSR port.
// ----------------------------------------------------------------------------
module fic_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [fic_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fic_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output fic_pkg::cfg_type                     cfg
);
   import fic_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_SIZE: cfg_in.min_size = SIZE_BITS'(csr_wdata);
            CSR_MAX_SIZE: cfg_in.max_size = SIZE_BITS'(csr_wdata);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_size <= MIN_SIZE_RESET;
         cfg_ff.max_size <= MAX_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/fic_in_reg.sv @@
// ----------------------------------------------------------------------------
// Firmware image checker input register
// Registers one incoming byte transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module fic_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fic_pkg::req_type req_data,
   output logic             item_valid,
   output fic_pkg::req_type item,
   input  logic             take
);
   import fic_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/fic_core.sv @@
// ----------------------------------------------------------------------------
// Firmware image checker core
// Updates the running Fletcher-32 sums, prefix matches and header words for
// one byte, and forms the image result on the final byte.
// ----------------------------------------------------------------------------
module fic_core #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  fic_pkg::cfg_type cfg,
   input  logic             item_valid,
   input  fic_pkg::req_type item,
   input  logic             out_free,
   output logic             take,
   output logic             result_load,
   output fic_pkg::rsp_type result
);
   import fic_pkg::*;

   localparam int unsigned CMP_BITS = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;
   localparam logic [COUNT_BITS-1:0] MAX_COUNT = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [15:0]           low_ff, low_in;
   logic [15:0]           high_ff, high_in;
   logic [7:0]            held_ff, held_in;
   logic                  pending_ff, pending_in;
   logic                  v3_ok_ff, v3_ok_in;
   logic                  patch_ok_ff, patch_ok_in;
   logic [31:0]           version_ff, version_in;
   logic [31:0]           build_ff, build_in;
   logic [31:0]           regions_ff, regions_in;

   logic [COUNT_BITS-1:0] off;
   logic                  counting;
   logic                  add;
   logic [15:0]           word;
   logic [CMP_BITS-1:0]   cmp_len;
   logic                  size_bad;

   assign take        = item_valid && (!item.last_byte || out_free);
   assign result_load = take && item.last_byte;

   always_comb begin
      off         = count_ff;
      counting    = !(ovf_ff || (count_ff == MAX_COUNT));
      count_in    = count_ff;
      ovf_in      = ovf_ff || !counting;
      v3_ok_in    = v3_ok_ff;
      patch_ok_in = patch_ok_ff;
      version_in  = version_ff;
      build_in    = build_ff;
      regions_in  = regions_ff;

      if (counting) begin
         count_in = count_ff + 1'b1;
         if (off < COUNT_BITS'(PREFIX_LEN)) begin
            if (item.byte_value != MAGIC_V3[off[2:0]]) begin
               v3_ok_in = 1'b0;
            end
            if (item.byte_value != MAGIC_PATCH[off[2:0]]) begin
               patch_ok_in = 1'b0;
            end
         end else if (off >= COUNT_BITS'(OFF_VERSION) && off < COUNT_BITS'(OFF_BUILD)) begin
            version_in[{off[1:0], 3'b000} +: 8] = item.byte_value;
         end else if (off >= COUNT_BITS'(OFF_BUILD) && off < COUNT_BITS'(OFF_REGIONS)) begin
            build_in[{off[1:0], 3'b000} +: 8] = item.byte_value;
         end else if (off >= COUNT_BITS'(OFF_REGIONS) && off < COUNT_BITS'(V3_MIN_LEN)) begin
            regions_in[{off[1:0], 3'b000} +: 8] = item.byte_value;
         end
      end

      // A trailing odd byte closes the image as a word with a zero high byte.
      if (pending_ff) begin
         add        = 1'b1;
         word       = {item.byte_value, held_ff};
         held_in    = 8'd0;
         pending_in = 1'b0;
      end else begin
         add        = item.last_byte;
         word       = {8'd0, item.byte_value};
         held_in    = item.byte_value;
         pending_in = 1'b1;
      end

      low_in  = add ? mod_add(low_ff, word) : low_ff;
      high_in = add ? mod_add(high_ff, low_in) : high_ff;

      cmp_len  = CMP_BITS'(count_in);
      size_bad = ovf_in || (cmp_len < CMP_BITS'(cfg.min_size))
                 || (cmp_len > CMP_BITS'(cfg.max_size));

      result = '0;
      if (size_bad) begin
         result.status = STATUS_SIZE;
      end else begin
         result.status       = STATUS_OK;
         result.checksum     = {high_in, low_in};
         result.image_length = SIZE_BITS'(count_in);
         if (count_in >= COUNT_BITS'(V3_MIN_LEN) && v3_ok_in) begin
            result.flavour       = FLAVOUR_V3;
            result.image_version = version_in;
            result.build_stamp   = build_in;
            result.num_regions   = regions_in;
            if (regions_in == 32'd0 || regions_in > MAX_REGIONS) begin
               result.status = STATUS_REGION;
            end
         end else if (count_in >= COUNT_BITS'(PREFIX_LEN) && patch_ok_in) begin
            result.flavour = FLAVOUR_PATCH;
         end
      end

      if (item.last_byte) begin
         count_in    = '0;
         ovf_in      = 1'b0;
         low_in      = MOD_SUM;
         high_in     = MOD_SUM;
         held_in     = 8'd0;
         pending_in  = 1'b0;
         v3_ok_in    = 1'b1;
         patch_ok_in = 1'b1;
         version_in  = 32'd0;
         build_in    = 32'd0;
         regions_in  = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         low_ff      <= MOD_SUM;
         high_ff     <= MOD_SUM;
         held_ff     <= 8'd0;
         pending_ff  <= 1'b0;
         v3_ok_ff    <= 1'b1;
         patch_ok_ff <= 1'b1;
         version_ff  <= 32'd0;
         build_ff    <= 32'd0;
         regions_ff  <= 32'd0;
      end else if (take) begin
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         held_ff     <= held_in;
         pending_ff  <= pending_in;
         v3_ok_ff    <= v3_ok_in;
         patch_ok_ff <= patch_ok_in;
         version_ff  <= version_in;
         build_ff    <= build_in;
         regions_ff  <= regions_in;
      end
   end

   // The state is back at its reset values after every image.
   assert property (@(posedge clock) disable iff (reset)
      result_load |=> (count_ff == '0 && !ovf_ff && !pending_ff && low_ff == MOD_SUM))
      else $error("image state not cleared after result");

   // Each byte of an image but the last flips the odd-byte flag.
   assert property (@(posedge clock) disable iff (reset)
      (take && !item.last_byte) |=> (pending_ff != $past(pending_ff)))
      else $error("odd-byte flag did not toggle");

   // Overflow only happens once the counter has saturated.
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == MAX_COUNT))
      else $error("overflow flag set below saturation");

   // A result is only produced when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      result_load |-> out_free)
      else $error("result loaded into a busy output register");

endmodule

@@ rtl/fic_out_reg.sv @@
// ----------------------------------------------------------------------------
// Firmware image checker output register
// Holds one result transaction until the consumer accepts it.
// ----------------------------------------------------------------------------
module fic_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  fic_pkg::rsp_type data,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fic_pkg::rsp_type rsp_data
);
   import fic_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
